// ===== design/heading_pd_turn_controller_top_defines.svh =====
// Assertion macros shared by the heading turn controller checkers.
`ifndef HEADING_PD_TURN_CONTROLLER_TOP_DEFINES_SVH
`define HEADING_PD_TURN_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HPDTC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("heading controller check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HPDTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("heading controller check failed");

`endif

// ===== design/hpdtc_pkg.sv =====
// Shared constants and types of the heading turn controller.
package hpdtc_pkg;

	localparam int CFG_INDEX_W = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_TARGET    = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P    = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D    = 8'd3;

	localparam logic [15:0] TARGET_RESET    = 16'd0;
	localparam logic [14:0] TOLERANCE_RESET = 15'd100;
	localparam logic [15:0] GAIN_P_RESET    = 16'd3473;
	localparam logic [15:0] GAIN_D_RESET    = 16'd148;

	localparam logic [15:0] HDG_HALF   = 16'd18000;
	localparam logic [15:0] TGT_LOW    = 16'd1000;
	localparam logic [15:0] TGT_HIGH   = 16'd35000;

	localparam logic signed [17:0] HALF_TURN = 18'sd18000;
	localparam logic signed [17:0] FULL_TURN = 18'sd36000;
	localparam logic signed [15:0] ERR_MAX   = 16'sd18000;

	localparam logic signed [34:0] ROUND_HALF = 35'sd2048;
	localparam logic signed [34:0] DRIVE_LIM  = 35'sd40960000;
	localparam logic signed [14:0] DRIVE_MAX  = 15'sd10000;

	typedef struct packed {
		logic signed [15:0] err;
		logic               done;
	} err_res_t;

endpackage

// ===== design/hpdtc_error.sv =====
// Wrapped heading error, saturation and tolerance test.
module hpdtc_error (
	input  logic [15:0]         heading,
	input  logic [15:0]         target,
	input  logic [14:0]         tolerance,
	output hpdtc_pkg::err_res_t res
);

	logic signed [17:0] diff;
	logic signed [17:0] wrapped;
	logic signed [17:0] chosen;
	logic signed [15:0] err;
	logic [15:0]        mag;
	logic               special;

	assign diff    = $signed({2'b00, heading}) - $signed({2'b00, target});
	assign special = (heading > hpdtc_pkg::HDG_HALF) &&
		((target < hpdtc_pkg::TGT_LOW) || (target > hpdtc_pkg::TGT_HIGH));

	always_comb begin
		if (diff > hpdtc_pkg::HALF_TURN) begin
			wrapped = diff - hpdtc_pkg::FULL_TURN;
		end else if (diff < -hpdtc_pkg::HALF_TURN) begin
			wrapped = diff + hpdtc_pkg::FULL_TURN;
		end else begin
			wrapped = diff;
		end
		if (special) begin
			chosen = $signed({2'b00, heading}) - hpdtc_pkg::FULL_TURN;
		end else begin
			chosen = wrapped;
		end
		if (chosen > hpdtc_pkg::HALF_TURN) begin
			err = hpdtc_pkg::ERR_MAX;
		end else if (chosen < -hpdtc_pkg::HALF_TURN) begin
			err = -hpdtc_pkg::ERR_MAX;
		end else begin
			err = chosen[15:0];
		end
	end

	assign mag      = err[15] ? 16'(-err) : 16'(err);
	assign res.err  = err;
	assign res.done = mag <= {1'b0, tolerance};

endmodule

// ===== design/hpdtc_drive.sv =====
// Proportional-derivative drive with rounding and saturation.
module hpdtc_drive (
	input  logic signed [15:0] err,
	input  logic signed [15:0] last,
	input  logic [15:0]        gain_p,
	input  logic [15:0]        gain_d,
	input  logic               done,
	output logic signed [14:0] drive
);

	logic signed [16:0] gp_s;
	logic signed [16:0] gd_s;
	logic signed [16:0] delta;
	logic signed [32:0] prod_p;
	logic signed [33:0] prod_d;
	logic signed [34:0] rounded;

	assign gp_s    = $signed({1'b0, gain_p});
	assign gd_s    = $signed({1'b0, gain_d});
	assign delta   = 17'(err) - 17'(last);
	assign prod_p  = 33'(gp_s) * 33'(err);
	assign prod_d  = 34'(gd_s) * 34'(delta);
	assign rounded = 35'(prod_p) + 35'(prod_d) + hpdtc_pkg::ROUND_HALF;

	always_comb begin
		if (done) begin
			drive = '0;
		end else if (rounded >= hpdtc_pkg::DRIVE_LIM) begin
			drive = hpdtc_pkg::DRIVE_MAX;
		end else if (rounded < -hpdtc_pkg::DRIVE_LIM) begin
			drive = -hpdtc_pkg::DRIVE_MAX;
		end else begin
			drive = rounded[26:12];
		end
	end

endmodule

// ===== design/heading_pd_turn_controller_top.sv =====
// Top level of the heading turn controller: registers, handshake and datapath.
// An accepted word waits in the input register until its result enters the result register.
// Throughput: one word per cycle unless stalled, set by one input and one result register.
// The last error is updated as each result is captured, so back-to-back words chain.
// Reset clears the valid flags, the last error and the configuration to defaults.
module heading_pd_turn_controller_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [15:0]                       heading,
	input  logic                              start_req,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [14:0]                drive,
	output logic signed [15:0]                heading_error,
	output logic                              done_res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hpdtc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                       cfg_data
);

	logic [15:0]         target_q;
	logic [14:0]         tolerance_q;
	logic [15:0]         gain_p_q;
	logic [15:0]         gain_d_q;
	logic signed [15:0]  prev_err_q;
	logic                valid_s1;
	logic [15:0]         heading_s1;
	logic                start_s1;
	logic                out_valid_q;
	logic signed [14:0]  drive_q;
	logic signed [15:0]  err_q;
	logic                done_q;
	logic                advance;
	logic signed [15:0]  last;
	logic signed [14:0]  drive_c;
	hpdtc_pkg::err_res_t err_res;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign last      = start_s1 ? 16'sd0 : prev_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= hpdtc_pkg::TARGET_RESET;
			tolerance_q <= hpdtc_pkg::TOLERANCE_RESET;
			gain_p_q    <= hpdtc_pkg::GAIN_P_RESET;
			gain_d_q    <= hpdtc_pkg::GAIN_D_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				hpdtc_pkg::REG_TARGET:    target_q    <= cfg_data;
				hpdtc_pkg::REG_TOLERANCE: tolerance_q <= cfg_data[14:0];
				hpdtc_pkg::REG_GAIN_P:    gain_p_q    <= cfg_data;
				hpdtc_pkg::REG_GAIN_D:    gain_d_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			prev_err_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (advance && valid_s1) begin
				prev_err_q <= err_res.err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			heading_s1 <= heading;
			start_s1   <= start_req;
		end
		if (advance && valid_s1) begin
			drive_q <= drive_c;
			err_q   <= err_res.err;
			done_q  <= err_res.done;
		end
	end

	hpdtc_error u_error (
		.heading   (heading_s1),
		.target    (target_q),
		.tolerance (tolerance_q),
		.res       (err_res)
	);

	hpdtc_drive u_drive (
		.err    (err_res.err),
		.last   (last),
		.gain_p (gain_p_q),
		.gain_d (gain_d_q),
		.done   (err_res.done),
		.drive  (drive_c)
	);

	assign out_valid     = out_valid_q;
	assign drive         = drive_q;
	assign heading_error = err_q;
	assign done_res      = done_q;

endmodule

// ===== design/hpdtc_checker.sv =====
// Port-level checks of the heading turn controller, bound to the top level.
`include "heading_pd_turn_controller_top_defines.svh"

module hpdtc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [14:0] drive,
	input logic signed [15:0] heading_error,
	input logic               done_res
);

	`HPDTC_ASSERT_IMP(a_done_zero_drive, out_valid && done_res, drive == 15'sd0)
	`HPDTC_ASSERT_IMP(a_drive_range, out_valid,
		(drive <= 15'sd10000) && (drive >= -15'sd10000))
	`HPDTC_ASSERT_IMP(a_error_range, out_valid,
		(heading_error <= 16'sd18000) && (heading_error >= -16'sd18000))
	`HPDTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(drive) && $stable(heading_error) && $stable(done_res))

endmodule

bind heading_pd_turn_controller_top hpdtc_checker u_hpdtc_checker (.*);

// ===== bench/tb_heading_pd_turn_controller_top.sv =====
// Self-checking testbench of the heading turn controller with its own PD step predictor.
module tb_heading_pd_turn_controller_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     TURN_HALF       = 18000;
	localparam int     TURN_FULL       = 36000;
	localparam int     AIM_LOW         = 1000;
	localparam int     AIM_HIGH        = 35000;
	localparam int     DRIVE_CAP       = 10000;
	localparam int     GAIN_FRAC       = 12;
	localparam longint GAIN_HALF_LSB   = 64'sd2048;
	localparam longint DRIVE_SCALED    = 64'sd40960000;
	localparam int     PHASES          = 12;
	localparam int     WORDS_PER_PHASE = 32;
	localparam int     PRESSURE_PHASE  = 9;
	localparam int     LONG_HOLD       = 150;
	localparam int     CYCLE_LIMIT     = 200000;

	localparam logic [hpdtc_pkg::CFG_INDEX_W-1:0] REG_SPARE = 8'd7;

	typedef struct packed {
		logic signed [14:0] drive;
		logic signed [15:0] err;
		logic               done;
	} turn_res_t;

	typedef struct packed {
		logic [15:0] hdg;
		logic        first;
		logic        typed;
		turn_res_t   want;
	} probe_row_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [15:0]                       heading = '0;
	logic                              start_req = 1'b0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [14:0]                drive;
	logic signed [15:0]                heading_error;
	logic                              done_res;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [hpdtc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [15:0]                       cfg_data = '0;

	logic      row_typed = 1'b0;
	turn_res_t row_want = '0;

	logic [15:0] ctl_target = hpdtc_pkg::TARGET_RESET;
	logic [14:0] ctl_tolerance = hpdtc_pkg::TOLERANCE_RESET;
	logic [15:0] ctl_gain_p = hpdtc_pkg::GAIN_P_RESET;
	logic [15:0] ctl_gain_d = hpdtc_pkg::GAIN_D_RESET;
	int          last_error = 0;

	turn_res_t expected_turns [$];

	int words_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int cfg_writes = 0;
	int done_seen = 0;
	int sat_seen = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int stall_left = 0;

	probe_row_t probe_rows [20] = '{
		'{16'd0,     1'b1, 1'b1, '{15'sd0,      16'sd0,      1'b1}},
		'{16'd100,   1'b0, 1'b1, '{15'sd0,      16'sd100,    1'b1}},
		'{16'd101,   1'b0, 1'b0, '0},
		'{16'd18000, 1'b0, 1'b1, '{15'sd10000,  16'sd18000,  1'b0}},
		'{16'd18001, 1'b0, 1'b1, '{-15'sd10000, -16'sd17999, 1'b0}},
		'{16'd35999, 1'b0, 1'b1, '{15'sd0,      -16'sd1,     1'b1}},
		'{16'd65535, 1'b0, 1'b1, '{15'sd10000,  16'sd18000,  1'b0}},
		'{16'd65535, 1'b1, 1'b1, '{15'sd10000,  16'sd18000,  1'b0}},
		'{16'd36000, 1'b0, 1'b1, '{15'sd0,      16'sd0,      1'b1}},
		'{16'd9000,  1'b1, 1'b0, '0},
		'{16'd9000,  1'b0, 1'b0, '0},
		'{16'd27000, 1'b0, 1'b0, '0},
		'{16'd17999, 1'b1, 1'b0, '0},
		'{16'd18002, 1'b0, 1'b0, '0},
		'{16'd32768, 1'b0, 1'b0, '0},
		'{16'h5555,  1'b1, 1'b0, '0},
		'{16'hAAAA,  1'b0, 1'b0, '0},
		'{16'h7FFF,  1'b0, 1'b0, '0},
		'{16'd99,    1'b1, 1'b1, '{15'sd0,      16'sd99,     1'b1}},
		'{16'd1,     1'b0, 1'b1, '{15'sd0,      16'sd1,      1'b1}}
	};

	heading_pd_turn_controller_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.heading       (heading),
		.start_req     (start_req),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive         (drive),
		.heading_error (heading_error),
		.done_res      (done_res),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic turn_res_t turn_step(input logic [15:0] hdg, input logic first);
		int        h;
		int        t;
		int        e;
		int        prior;
		longint    acc;
		turn_res_t r;
		h = hdg;
		t = ctl_target;
		prior = first ? 0 : last_error;
		e = h - t;
		if (e > TURN_HALF) begin
			e -= TURN_FULL;
		end else if (e < -TURN_HALF) begin
			e += TURN_FULL;
		end
		if (h > TURN_HALF && (t < AIM_LOW || t > AIM_HIGH)) begin
			e = h - TURN_FULL;
		end
		if (e > TURN_HALF) begin
			e = TURN_HALF;
		end else if (e < -TURN_HALF) begin
			e = -TURN_HALF;
		end
		r.err = 16'(e);
		r.done = ((e < 0) ? -e : e) <= int'(ctl_tolerance);
		r.drive = '0;
		if (!r.done) begin
			acc = longint'(ctl_gain_p) * e + longint'(ctl_gain_d) * (e - prior) + GAIN_HALF_LSB;
			if (acc >= DRIVE_SCALED) begin
				r.drive = 15'(DRIVE_CAP);
			end else if (acc < -DRIVE_SCALED) begin
				r.drive = 15'(-DRIVE_CAP);
			end else begin
				r.drive = 15'(((acc + DRIVE_SCALED) >>> GAIN_FRAC) - DRIVE_CAP);
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin : watch
		turn_res_t pred;
		turn_res_t want;
		turn_res_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				case (cfg_index)
					hpdtc_pkg::REG_TARGET:    ctl_target = cfg_data;
					hpdtc_pkg::REG_TOLERANCE: ctl_tolerance = cfg_data[14:0];
					hpdtc_pkg::REG_GAIN_P:    ctl_gain_p = cfg_data;
					hpdtc_pkg::REG_GAIN_D:    ctl_gain_d = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				pred = turn_step(heading, start_req);
				last_error = $signed(pred.err);
				expected_turns.push_back(row_typed ? row_want : pred);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				got = '{drive, heading_error, done_res};
				if (expected_turns.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected word: drive %0d error %0d done %0b",
							$signed(got.drive), $signed(got.err), got.done);
					end
				end else begin
					want = expected_turns.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch on word %0d: drive %0d/%0d error %0d/%0d done %0b/%0b (exp/got)",
								results_seen, $signed(want.drive), $signed(got.drive),
								$signed(want.err), $signed(got.err), want.done, got.done);
						end
					end
				end
				if (got.done) begin
					done_seen++;
				end
				if (got.drive == 15'(DRIVE_CAP) || got.drive == 15'(-DRIVE_CAP)) begin
					sat_seen++;
				end
			end
		end
	end

	always @(posedge clk) begin : sink
		if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			stall_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : watchdog
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_word(input logic [15:0] hdg, input logic first, input logic typed,
		input turn_res_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		heading <= hdg;
		start_req <= first;
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (results_seen < words_sent) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apply_config(input logic [15:0] tgt, input logic [15:0] tol,
		input logic [15:0] gp, input logic [15:0] gd);
		logic [hpdtc_pkg::CFG_INDEX_W-1:0] idx [5];
		logic [15:0]                       val [5];
		idx = '{hpdtc_pkg::REG_TARGET, hpdtc_pkg::REG_TOLERANCE, hpdtc_pkg::REG_GAIN_P,
			hpdtc_pkg::REG_GAIN_D, REG_SPARE};
		val = '{tgt, tol, gp, gd, 16'($urandom)};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : run
		int          hdg;
		int          prev_hdg;
		int          span;
		int          run_left;
		logic        first;
		logic [15:0] tgt;
		logic [15:0] tol;
		logic [15:0] gp;
		logic [15:0] gd;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 8;
		recv_idle_pct <= 62;
		for (int i = 0; i < $size(probe_rows); i++) begin
			send_word(probe_rows[i].hdg, probe_rows[i].first, probe_rows[i].typed,
				probe_rows[i].want);
		end
		prev_hdg = 0;
		run_left = 0;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: {tgt, tol, gp, gd} = {16'd35999, 16'd0, 16'hFFFF, 16'hFFFF};
				1: {tgt, tol, gp, gd} = {16'd500, 16'hFFFF, 16'd0, 16'd0};
				2: {tgt, tol, gp, gd} = {16'd35500, 16'd50, 16'd1000, 16'd4000};
				3: {tgt, tol, gp, gd} = {16'hFFFF, 16'd18000, 16'd4096, 16'd0};
				4: {tgt, tol, gp, gd} = {16'd0, 16'd0, 16'd3473, 16'hFFFF};
				5: {tgt, tol, gp, gd} = {16'd18000, 16'd10, 16'd200, 16'd1};
				default: begin
					tgt = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(35999));
					tol = {1'($urandom),
						($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(400))};
					gp = ($urandom_range(1) == 0) ? 16'($urandom_range(4095)) : 16'($urandom);
					gd = 16'($urandom);
				end
			endcase
			apply_config(tgt, tol, gp, gd);
			if (p < 4) begin
				send_idle_pct = 8;
				recv_idle_pct <= 62;
			end else if (p < 8) begin
				send_idle_pct = 62;
				recv_idle_pct <= 8;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			if (p == PRESSURE_PHASE) begin
				hold_asked <= hold_asked + 1;
			end
			span = ((tol[14:0] > 15'd400) ? 400 : int'(tol[14:0])) + 3;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				case ($urandom_range(9))
					0: hdg = $urandom_range(65535);
					1, 2: hdg = (int'(tgt) % TURN_FULL + TURN_FULL + int'($urandom_range(2 * span))
						- span) % TURN_FULL;
					3, 4, 5: hdg = (prev_hdg % TURN_FULL + TURN_FULL + int'($urandom_range(4000))
						- 2000) % TURN_FULL;
					default: hdg = $urandom_range(35999);
				endcase
				first = (run_left == 0) || ($urandom_range(19) == 0);
				if (run_left == 0) begin
					run_left = $urandom_range(12, 3);
				end
				run_left--;
				send_word(16'(hdg), first, 1'b0, '0);
				prev_hdg = hdg;
			end
		end
		settle();
		$display("Sent %0d heading words over %0d controller settings, %0d results checked.",
			words_sent, PHASES + 1, results_seen);
		$display("%0d within tolerance, %0d saturated drives, %0d register writes, %0d mismatches.",
			done_seen, sat_seen, cfg_writes, mismatches);
		if (mismatches == 0 && expected_turns.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
